// ----- src/trg_pkg.sv -----
// shared types, constants and tables of the procedural tile row generator
package trg_pkg;

    localparam int COORD_W    = 16;
    localparam int HASH_W     = 32;
    localparam int ROW_W      = 16;
    localparam int IN_TDATA_W = 40;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    // register stages from input to output register
    localparam int PIPE_DEPTH = 6;

    localparam int MAP_COLS_DEFAULT = 256;
    localparam int MAP_ROWS_DEFAULT = 128;

    localparam logic [CFG_INDEX_W-1:0] REG_HASH_SEED       = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND_MODE = 1'b1;

    localparam logic [HASH_W-1:0] HASH_MUL_COL = 32'h9e37_79b9;
    localparam logic [HASH_W-1:0] HASH_MUL_ROW = 32'h85eb_ca6b;
    localparam logic [HASH_W-1:0] HASH_MUL_MIX = 32'h7feb_352d;

    localparam logic [ROW_W-1:0] CHECK_EVEN  = 16'haaaa;
    localparam logic [ROW_W-1:0] CHECK_ODD   = 16'h5555;
    localparam logic [ROW_W-1:0] EDGE_SIDES  = 16'h8001;
    localparam logic [ROW_W-1:0] EDGE_FULL   = 16'hffff;
    localparam logic [ROW_W-1:0] MARK_TOP_2  = 16'h6000;
    localparam logic [ROW_W-1:0] MARK_TOP_3  = 16'h7000;
    localparam logic [ROW_W-1:0] MARK_BOT_2  = 16'h0006;
    localparam logic [ROW_W-1:0] MARK_BOT_3  = 16'h000e;

    typedef struct packed {
        logic [3:0] pixel_row;
        logic [1:0] plane_index;
    } side_t;

    localparam logic [4:0] FONT_ROWS [112] = '{
        5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e,
        5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e,
        5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f,
        5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e,
        5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02,
        5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e,
        5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e,
        5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08,
        5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e,
        5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e,
        5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11,
        5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e,
        5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e,
        5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e,
        5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f,
        5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10
    };

    localparam logic [2:0] BACK_COL [4] = '{3'd1, 3'd2, 3'd3, 3'd4};
    localparam logic [2:0] INK_COL  [4] = '{3'd7, 3'd6, 3'd5, 3'd7};
    localparam logic [2:0] EDGE_COL [4] = '{3'd5, 3'd3, 3'd1, 3'd6};

    // glyph row for pixel rows 1..14, blank elsewhere
    function automatic logic [4:0] font_row(input logic [3:0] glyph, input logic [3:0] y);
        logic [2:0] rsel;
        logic [6:0] idx;
        rsel = 3'((y - 4'd1) >> 1);
        idx  = 7'({3'b000, glyph} * 7'd7) + {4'b0000, rsel};
        if (y == 4'd0 || y == 4'd15)
        begin
            return 5'h00;
        end
        return FONT_ROWS[idx];
    endfunction

endpackage

// ----- src/trg_coord_reduce.sv -----
// two-stage reduction of tile column and row modulo the map size
module trg_coord_reduce
    import trg_pkg::*;
#(
    parameter int MAP_COLS = MAP_COLS_DEFAULT,
    parameter int MAP_ROWS = MAP_ROWS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COORD_W-1:0] in_col,
    input  logic [COORD_W-1:0] in_row,
    input  side_t              in_side,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COORD_W-1:0] out_col,
    output logic [COORD_W-1:0] out_row,
    output side_t              out_side
);

    localparam logic [32:0] COL_RECIP =
        33'(((64'd1 << 32) + 64'(MAP_COLS) - 64'd1) / 64'(MAP_COLS));
    localparam logic [32:0] ROW_RECIP =
        33'(((64'd1 << 32) + 64'(MAP_ROWS) - 64'd1) / 64'(MAP_ROWS));
    localparam logic [16:0] COLS_M = 17'(MAP_COLS);
    localparam logic [16:0] ROWS_M = 17'(MAP_ROWS);

    logic               v1_reg, v2_reg;
    logic               adv1, adv2;
    logic [COORD_W-1:0] col1_reg, row1_reg;
    logic [48:0]        col_prod_reg, row_prod_reg;
    logic [48:0]        col_prod_next, row_prod_next;
    side_t              side1_reg, side2_reg;
    logic [COORD_W-1:0] col2_reg, row2_reg;
    logic [COORD_W-1:0] col2_next, row2_next;
    logic [32:0]        col_back, row_back;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // quotient estimate by reciprocal, exact for 16-bit operands
    assign col_prod_next = 49'(in_col) * 49'(COL_RECIP);
    assign row_prod_next = 49'(in_row) * 49'(ROW_RECIP);

    assign col_back  = 33'(col_prod_reg[47:32]) * 33'(COLS_M);
    assign row_back  = 33'(row_prod_reg[47:32]) * 33'(ROWS_M);
    assign col2_next = col1_reg - col_back[COORD_W-1:0];
    assign row2_next = row1_reg - row_back[COORD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            col1_reg     <= in_col;
            row1_reg     <= in_row;
            col_prod_reg <= col_prod_next;
            row_prod_reg <= row_prod_next;
            side1_reg    <= in_side;
        end
        if (adv2)
        begin
            col2_reg  <= col2_next;
            row2_reg  <= row2_next;
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_col   = col2_reg;
    assign out_row   = row2_reg;
    assign out_side  = side2_reg;

endmodule

// ----- src/trg_tile_hash.sv -----
// two-stage multiply-xorshift tile hash
module trg_tile_hash
    import trg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [HASH_W-1:0]  hash_seed,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COORD_W-1:0] in_col,
    input  logic [COORD_W-1:0] in_row,
    input  side_t              in_side,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [HASH_W-1:0]  out_hash,
    output side_t              out_side
);

    logic              v1_reg, v2_reg;
    logic              adv1, adv2;
    logic [HASH_W-1:0] px_reg, py_reg, px_next, py_next;
    logic [HASH_W-1:0] mix, fold, mul_next, mul_reg;
    side_t             side1_reg, side2_reg;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign px_next  = {16'h0000, in_col} * HASH_MUL_COL;
    assign py_next  = {16'h0000, in_row} * HASH_MUL_ROW;
    assign mix      = px_reg ^ py_reg ^ hash_seed;
    assign fold     = mix ^ (mix >> 16);
    assign mul_next = fold * HASH_MUL_MIX;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            side1_reg <= in_side;
        end
        if (adv2)
        begin
            mul_reg   <= mul_next;
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_hash  = mul_reg;
    assign out_side  = side2_reg;

endmodule

// ----- src/trg_row_render.sv -----
// glyph lookup and row word composition, ending in the output register
module trg_row_render
    import trg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              foreground_mode,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [HASH_W-1:0] in_hash,
    input  side_t             in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ROW_W-1:0]  out_row_word
);

    logic              v1_reg, v2_reg;
    logic              adv1, adv2;
    logic [HASH_W-1:0] hash_fin;
    logic [4:0]        font_next, font_reg;
    logic [1:0]        variant_reg;
    side_t             side1_reg;
    logic [ROW_W-1:0]  row_reg, row_next;

    logic [3:0]        y;
    logic              top_hit, bot_hit;
    logic [ROW_W-1:0]  edge_m, mark_raw, mark_m, letter_m, glyph_m, bg_m, check_m;
    logic [3:0]        bg_c, ink_c, edge_c;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign hash_fin  = in_hash ^ (in_hash >> 15);
    assign font_next = font_row(hash_fin[3:0], in_side.pixel_row);

    always_comb
    begin
        y       = side1_reg.pixel_row;
        edge_m  = (y == 4'd0 || y == 4'd15) ? EDGE_FULL : EDGE_SIDES;
        // marker square is 2 or 3 pixels
        top_hit = (y < 4'd2) || (variant_reg[0] && y == 4'd2);
        bot_hit = variant_reg[1] && ((y >= 4'd13) || (variant_reg[0] && y == 4'd12));
        mark_raw = '0;
        if (top_hit)
        begin
            mark_raw = mark_raw | (variant_reg[0] ? MARK_TOP_3 : MARK_TOP_2);
        end
        if (bot_hit)
        begin
            mark_raw = mark_raw | (variant_reg[0] ? MARK_BOT_3 : MARK_BOT_2);
        end
        mark_m   = mark_raw & ~edge_m;
        letter_m = {3'b000,
                    font_reg[4], font_reg[4], font_reg[3], font_reg[3],
                    font_reg[2], font_reg[2], font_reg[1], font_reg[1],
                    font_reg[0], font_reg[0], 3'b000};
        glyph_m  = letter_m & ~(edge_m | mark_m);
        bg_m     = ~(edge_m | mark_m | glyph_m);
        check_m  = y[0] ? CHECK_ODD : CHECK_EVEN;

        bg_c   = {!foreground_mode, BACK_COL[variant_reg]};
        ink_c  = {!foreground_mode, INK_COL[variant_reg]};
        edge_c = {!foreground_mode, EDGE_COL[variant_reg]};

        row_next = '0;
        if (bg_c[side1_reg.plane_index])
        begin
            row_next = foreground_mode ? (bg_m & check_m) : bg_m;
        end
        if (edge_c[side1_reg.plane_index])
        begin
            row_next = row_next | edge_m;
        end
        if (ink_c[side1_reg.plane_index])
        begin
            row_next = row_next | mark_m | glyph_m;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            font_reg    <= font_next;
            variant_reg <= hash_fin[5:4];
            side1_reg   <= in_side;
        end
        if (adv2)
        begin
            row_reg <= row_next;
        end
    end

    assign out_valid    = v2_reg;
    assign out_row_word = row_reg;

endmodule

// ----- src/procedural_tile_row_generator_top.sv -----
// top level of the procedural tile row generator
// One row word per clock: an item enters on every cycle that the output side keeps up. The six
// register stages are coordinate reduction (reciprocal multiply, then back-multiply and subtract),
// the hash (coordinate multiplies, then the mixing multiply), and rendering (glyph ROM lookup, then
// row composition into the output register). Each stage holds its item while the stage after it is
// full and stalled, so bubbles are squeezed out and new items are taken while a finished row word
// waits. Configuration writes are always ready. The seed and the mode are read in later stages, so
// write them only while no item is in flight.
module procedural_tile_row_generator_top
    import trg_pkg::*;
#(
    parameter int MAP_COLS = MAP_COLS_DEFAULT,
    parameter int MAP_ROWS = MAP_ROWS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tile_col[15:0], tile_row[31:16], pixel_row[35:32], plane_index[37:36], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // row_word[15:0]
    output logic [ROW_W-1:0]       m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int INFLIGHT_W = $clog2(PIPE_DEPTH + 1);

    logic [HASH_W-1:0]     hash_seed_reg;
    logic                  fg_mode_reg;

    side_t                 in_side;
    logic                  red_valid, red_ready;
    logic [COORD_W-1:0]    red_col, red_row;
    side_t                 red_side;
    logic                  hash_valid, ren_ready;
    logic [HASH_W-1:0]     hash_val;
    side_t                 hash_side;

    logic [INFLIGHT_W-1:0] inflight_reg, inflight_next;
    logic                  in_acc, out_acc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg <= '0;
            fg_mode_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HASH_SEED:       hash_seed_reg <= cfg_data;
                REG_FOREGROUND_MODE: fg_mode_reg   <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    assign in_side.pixel_row   = s_axis_tdata[35:32];
    assign in_side.plane_index = s_axis_tdata[37:36];

    trg_coord_reduce #(
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS)
    ) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_col    (s_axis_tdata[15:0]),
        .in_row    (s_axis_tdata[31:16]),
        .in_side   (in_side),
        .out_valid (red_valid),
        .out_ready (red_ready),
        .out_col   (red_col),
        .out_row   (red_row),
        .out_side  (red_side)
    );

    trg_tile_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .hash_seed (hash_seed_reg),
        .in_valid  (red_valid),
        .in_ready  (red_ready),
        .in_col    (red_col),
        .in_row    (red_row),
        .in_side   (red_side),
        .out_valid (hash_valid),
        .out_ready (ren_ready),
        .out_hash  (hash_val),
        .out_side  (hash_side)
    );

    trg_row_render u_render (
        .clk             (clk),
        .rst_n           (rst_n),
        .foreground_mode (fg_mode_reg),
        .in_valid        (hash_valid),
        .in_ready        (ren_ready),
        .in_hash         (hash_val),
        .in_side         (hash_side),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_row_word    (m_axis_tdata)
    );

    // items in flight, for checking only
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign inflight_next = inflight_reg + INFLIGHT_W'(in_acc) - INFLIGHT_W'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_no_phantom_item: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == '0 |-> !m_axis_tvalid)
        else $error("row word shown with no item in flight");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= INFLIGHT_W'(PIPE_DEPTH))
        else $error("more items in flight than pipeline stages");

    a_empty_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> ren_ready)
        else $error("render stage stalled with empty output register");

endmodule

// ----- tb/sv/tb_procedural_tile_row_generator_top.sv -----
// testbench of the procedural tile row generator: predicted row words checked against the block
module tb_procedural_tile_row_generator_top
    import trg_pkg::*;
();

    localparam int MAP_COLS     = 256;
    localparam int MAP_ROWS     = 128;
    localparam int IDLE_LIMIT   = 5000;
    localparam int PHASE_ITEMS  = 280;

    localparam bit [31:0] MIX_COL  = 32'h9e37_79b9;
    localparam bit [31:0] MIX_ROW  = 32'h85eb_ca6b;
    localparam bit [31:0] MIX_HASH = 32'h7feb_352d;

    localparam bit [4:0] GLYPH_FONT [112] = '{
        5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e,
        5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e,
        5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f,
        5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e,
        5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02,
        5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e,
        5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e,
        5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08,
        5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e,
        5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e,
        5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11,
        5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e,
        5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e,
        5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e,
        5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f,
        5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10
    };

    localparam bit [3:0] PAPER_SHADE [4] = '{4'd1, 4'd2, 4'd3, 4'd4};
    localparam bit [3:0] INK_SHADE   [4] = '{4'd7, 4'd6, 4'd5, 4'd7};
    localparam bit [3:0] FRAME_SHADE [4] = '{4'd5, 4'd3, 4'd1, 4'd6};

    class row_word_scoreboard;
        bit [31:0] seed;
        bit        foreground;
        bit [15:0] expected_rows [$];
        int        failures;

        function void write_reg(bit [CFG_INDEX_W-1:0] index, bit [31:0] value);
            if (index == REG_HASH_SEED)
            begin
                seed = value;
            end
            else if (index == REG_FOREGROUND_MODE)
            begin
                foreground = value[0];
            end
        endfunction

        function bit [15:0] run_mask(int unsigned first, int unsigned count);
            bit [15:0]   m;
            int unsigned p;
            m = '0;
            for (int unsigned i = 0; i < count; i++)
            begin
                p = first + i;
                if (p < 16)
                begin
                    m |= 16'h8000 >> p;
                end
            end
            return m;
        endfunction

        function bit [15:0] letter_span_mask(bit [3:0] glyph, bit [3:0] y);
            bit [15:0] m;
            bit [4:0]  bits;
            m = '0;
            if (y < 1 || y >= 15)
            begin
                return m;
            end
            bits = GLYPH_FONT[int'(glyph) * 7 + ((int'(y) - 1) >> 1)];
            for (int gx = 0; gx < 5; gx++)
            begin
                if (bits[4 - gx])
                begin
                    m |= run_mask(3 + gx * 2, 2);
                end
            end
            return m;
        endfunction

        function bit [15:0] corner_square_mask(bit [1:0] variant, bit [3:0] y);
            bit [15:0]   m;
            int unsigned size;
            size = 2 + variant[0];
            m = '0;
            if (y < size)
            begin
                m |= run_mask(1, size);
            end
            if (variant >= 2 && y >= 15 - size)
            begin
                m |= run_mask(15 - size, size);
            end
            return m;
        endfunction

        function bit [15:0] predict_row_word(bit [15:0] col, bit [15:0] row, bit [3:0] y,
                                             bit [1:0] plane);
            bit [31:0] cx;
            bit [31:0] cy;
            bit [31:0] h;
            bit [1:0]  variant;
            bit [3:0]  base;
            bit [3:0]  paper;
            bit [3:0]  ink;
            bit [3:0]  frame;
            bit [15:0] frame_m;
            bit [15:0] mark_m;
            bit [15:0] glyph_m;
            bit [15:0] paper_m;
            bit [15:0] word;
            cx = 32'(col) % MAP_COLS;
            cy = 32'(row) % MAP_ROWS;
            h = (cx * MIX_COL) ^ (cy * MIX_ROW) ^ seed;
            h ^= h >> 16;
            h = h * MIX_HASH;
            h ^= h >> 15;
            variant = h[5:4];
            base = foreground ? 4'd0 : 4'd8;
            paper = base + PAPER_SHADE[variant];
            ink = base + INK_SHADE[variant];
            frame = base + FRAME_SHADE[variant];
            frame_m = (y == 0 || y == 15) ? 16'hffff : 16'h8001;
            mark_m = corner_square_mask(variant, y) & ~frame_m;
            glyph_m = letter_span_mask(h[3:0], y) & ~(frame_m | mark_m);
            paper_m = ~(frame_m | mark_m | glyph_m);
            word = '0;
            if (paper[plane])
            begin
                if (foreground)
                begin
                    word |= paper_m & (y[0] ? 16'h5555 : 16'haaaa);
                end
                else
                begin
                    word |= paper_m;
                end
            end
            if (frame[plane])
            begin
                word |= frame_m;
            end
            if (ink[plane])
            begin
                word |= mark_m | glyph_m;
            end
            return word;
        endfunction

        function void note_item(bit [15:0] col, bit [15:0] row, bit [3:0] y, bit [1:0] plane);
            expected_rows.push_back(predict_row_word(col, row, y, plane));
        endfunction

        function void check_row(bit [15:0] actual);
            bit [15:0] want;
            if (expected_rows.size() == 0)
            begin
                failures++;
                $error("row_word: expected none, actual %h", actual);
                return;
            end
            want = expected_rows.pop_front();
            if (want !== actual)
            begin
                failures++;
                $error("row_word: expected %h, actual %h", want, actual);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [ROW_W-1:0]       m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    row_word_scoreboard board = new;
    bit                 steady = 1'b0;
    int                 quiet_cycles = 0;

    procedural_tile_row_generator_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // result side: check accepted row words, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                board.check_row(m_axis_tdata);
            end
            m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 15);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("[procedural_tile_row_generator_top] ERROR");
                $finish;
            end
        end
    end

    task automatic send_tile_row(bit [15:0] col, bit [15:0] row, bit [3:0] y, bit [1:0] plane);
        while (!steady && $urandom_range(99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, plane, y, row, col};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        board.note_item(col, row, y, plane);
    endtask

    task automatic write_reg(bit [CFG_INDEX_W-1:0] index, bit [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        board.write_reg(index, value);
    endtask

    task automatic set_layer(bit [31:0] seed, bit foreground);
        s_axis_tvalid <= 1'b0;
        while (board.expected_rows.size() != 0)
        begin
            @(posedge clk);
        end
        write_reg(REG_HASH_SEED, seed);
        write_reg(REG_FOREGROUND_MODE, {31'b0, foreground});
        cfg_valid <= 1'b0;
    endtask

    // mostly whole tiles swept top to bottom, the rest scattered rows
    task automatic run_random(int count);
        int        sent;
        bit [15:0] col;
        bit [15:0] row;
        bit [1:0]  plane;
        sent = 0;
        while (sent < count)
        begin
            col = 16'($urandom);
            row = 16'($urandom);
            plane = 2'($urandom_range(3));
            if ($urandom_range(2) != 0)
            begin
                for (int y = 0; y < 16; y++)
                begin
                    send_tile_row(col, row, 4'(y), plane);
                end
                sent += 16;
            end
            else
            begin
                send_tile_row(col, row, 4'($urandom_range(15)), plane);
                sent++;
            end
        end
    endtask

    initial
    begin
        bit [15:0] edge_cols [5];
        bit [15:0] edge_rows [5];
        edge_cols = '{16'h0000, 16'hffff, 16'h00ff, 16'h0100, 16'h8000};
        edge_rows = '{16'h0000, 16'hffff, 16'h007f, 16'h0080, 16'haaaa};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 20; i++)
        begin
            send_tile_row(edge_cols[i % 5], edge_rows[(i + 2) % 5], 4'(i % 16), 2'(i % 4));
        end

        set_layer(32'hffff_ffff, 1'b1);
        run_random(PHASE_ITEMS);
        set_layer($urandom, 1'b0);
        steady = 1'b1;
        run_random(PHASE_ITEMS);
        steady = 1'b0;
        set_layer($urandom, 1'b1);
        run_random(PHASE_ITEMS);
        set_layer(32'h0000_0000, 1'b1);
        run_random(PHASE_ITEMS);
        set_layer(32'h8000_0001, 1'b0);
        run_random(PHASE_ITEMS);

        s_axis_tvalid <= 1'b0;
        while (board.expected_rows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        if (board.failures == 0 && board.expected_rows.size() == 0)
        begin
            $display("[procedural_tile_row_generator_top] OK");
        end
        else
        begin
            $display("[procedural_tile_row_generator_top] ERROR");
        end
        $finish;
    end

endmodule
